FILE: src/aip_pkg.sv
// Shared types, constants and character helpers for the ASCII integer parser.
package aip_pkg;

  localparam int POSITION_WIDTH = 16;
  localparam int BASE_WIDTH     = 6;
  localparam int VALUE_WIDTH    = 64;
  localparam int OFFSET_WIDTH   = 16;
  localparam int PROD_WIDTH     = VALUE_WIDTH + BASE_WIDTH;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  localparam logic [BASE_WIDTH-1:0] BASE_AUTO    = 6'd0;
  localparam logic [BASE_WIDTH-1:0] BASE_INVALID = 6'd1;
  localparam logic [BASE_WIDTH-1:0] BASE_BIN     = 6'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_OCT     = 6'd8;
  localparam logic [BASE_WIDTH-1:0] BASE_DEC     = 6'd10;
  localparam logic [BASE_WIDTH-1:0] BASE_HEX     = 6'd16;
  localparam logic [BASE_WIDTH-1:0] BASE_MAX     = 6'd36;
  localparam logic [BASE_WIDTH-1:0] DIGIT_NONE   = 6'd36;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHAR_UP_B  = 8'h42;
  localparam logic [7:0] CHAR_LO_B  = 8'h62;
  localparam logic [7:0] CHAR_UP_X  = 8'h58;
  localparam logic [7:0] CHAR_LO_X  = 8'h78;
  localparam logic [7:0] DIGIT_ALPHA_OFS = 8'd10;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       string_start;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] parsed_value;
    logic [OFFSET_WIDTH-1:0]       end_offset;
    logic                          digits_found;
    logic                          overflow_flag;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_stage_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic [BASE_WIDTH-1:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'(DIGIT_NONE);
    if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
      v = c - CHAR_ZERO;
    end else if ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z)) begin
      v = c - CHAR_LO_A + DIGIT_ALPHA_OFS;
    end else if ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) begin
      v = c - CHAR_UP_A + DIGIT_ALPHA_OFS;
    end
    return v[BASE_WIDTH-1:0];
  endfunction

  function automatic logic [POSITION_WIDTH-1:0] sat_inc(input logic [POSITION_WIDTH-1:0] p);
    return (p == POS_MAX) ? p : p + 1'b1;
  endfunction

endpackage

FILE: src/aip_input_reg.sv
// Input register stage: captures one character transfer and holds it for the parse core.
module aip_input_reg
  import aip_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  logic      take,
  output in_stage_t stage
);

  logic     valid;
  in_item_t item;

  assign in_stall = valid && !take;
  assign stage    = '{valid: valid, item: item};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      valid <= 1'b1;
      item  <= in_data;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

endmodule

FILE: src/aip_parse_core.sv
// Parse core: per-character state update, base register and result register.
module aip_parse_core
  import aip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [BASE_WIDTH-1:0] cfg_data,
  input  in_stage_t             stage,
  output logic                  take,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  typedef enum logic [2:0] {
    PH_DONE, PH_SPACE, PH_SIGN, PH_ZERO, PH_PREFIX, PH_DIGITS
  } phase_t;

  logic [BASE_WIDTH-1:0]     number_base;
  phase_t                    phase, phase_next;
  logic [VALUE_WIDTH-1:0]    accumulator, accumulator_next;
  logic                      negative_sign, negative_sign_next;
  logic [BASE_WIDTH-1:0]     effective_base, effective_base_next;
  logic [POSITION_WIDTH-1:0] char_position, char_position_next;
  logic [POSITION_WIDTH-1:0] fallback_offset, fallback_offset_next;
  logic                      seen_digit, seen_digit_next;
  logic                      overflow_seen, overflow_seen_next;

  logic                      emit;
  logic [POSITION_WIDTH-1:0] emit_offset;
  logic                      go;
  logic                      do_acc;
  logic [BASE_WIDTH-1:0]     digit;
  logic [PROD_WIDTH-1:0]     product;
  logic [7:0]                c;

  assign take  = stage.valid && (!out_valid || !out_stall);
  assign c     = stage.item.char_byte;
  assign digit = digit_value(c);

  always_comb begin
    phase_next           = phase;
    accumulator_next     = accumulator;
    negative_sign_next   = negative_sign;
    effective_base_next  = effective_base;
    char_position_next   = char_position;
    fallback_offset_next = fallback_offset;
    seen_digit_next      = seen_digit;
    overflow_seen_next   = overflow_seen;
    emit                 = 1'b0;
    emit_offset          = '0;
    go                   = 1'b1;
    do_acc               = 1'b0;
    product              = '0;

    if (stage.item.string_start) begin
      accumulator_next     = '0;
      negative_sign_next   = 1'b0;
      char_position_next   = '0;
      fallback_offset_next = '0;
      seen_digit_next      = 1'b0;
      overflow_seen_next   = 1'b0;
      effective_base_next  = number_base;
      if ((number_base == BASE_INVALID) || (number_base > BASE_MAX)) begin
        emit       = 1'b1;
        phase_next = PH_DONE;
        go         = 1'b0;
      end else begin
        phase_next = PH_SPACE;
      end
    end

    if (go && (phase_next == PH_DONE)) begin
      go = 1'b0;
    end

    if (go && (phase_next == PH_SPACE)) begin
      if (is_space(c)) begin
        char_position_next = sat_inc(char_position_next);
        go = 1'b0;
      end else begin
        phase_next = PH_SIGN;
        if ((c == CHAR_MINUS) || (c == CHAR_PLUS)) begin
          negative_sign_next = (c == CHAR_MINUS);
          char_position_next = sat_inc(char_position_next);
          go = 1'b0;
        end
      end
    end

    if (go && (phase_next == PH_SIGN)) begin
      if (c == CHAR_ZERO) begin
        seen_digit_next      = 1'b1;
        fallback_offset_next = sat_inc(char_position_next);
        char_position_next   = fallback_offset_next;
        phase_next           = PH_ZERO;
        go                   = 1'b0;
      end else begin
        if (effective_base_next == BASE_AUTO) begin
          effective_base_next = BASE_DEC;
        end
        phase_next = PH_DIGITS;
      end
    end

    if (go && (phase_next == PH_ZERO)) begin
      if (((c == CHAR_LO_X) || (c == CHAR_UP_X)) &&
          ((effective_base_next == BASE_AUTO) || (effective_base_next == BASE_HEX))) begin
        effective_base_next = BASE_HEX;
        phase_next          = PH_PREFIX;
        char_position_next  = sat_inc(char_position_next);
        go                  = 1'b0;
      end else if (((c == CHAR_LO_B) || (c == CHAR_UP_B)) &&
          ((effective_base_next == BASE_AUTO) || (effective_base_next == BASE_BIN))) begin
        effective_base_next = BASE_BIN;
        phase_next          = PH_PREFIX;
        char_position_next  = sat_inc(char_position_next);
        go                  = 1'b0;
      end else begin
        if (effective_base_next == BASE_AUTO) begin
          effective_base_next = BASE_OCT;
        end
        phase_next = PH_DIGITS;
      end
    end

    if (go) begin
      if (digit < effective_base_next) begin
        do_acc             = 1'b1;
        phase_next         = PH_DIGITS;
        char_position_next = sat_inc(char_position_next);
      end else begin
        emit        = 1'b1;
        emit_offset = (phase_next == PH_PREFIX) ? fallback_offset_next :
                      (seen_digit_next ? char_position_next : '0);
        phase_next  = PH_DONE;
      end
    end

    if (do_acc) begin
      product = PROD_WIDTH'(accumulator_next) * PROD_WIDTH'(effective_base_next)
              + PROD_WIDTH'(digit);
      accumulator_next = product[VALUE_WIDTH-1:0];
      seen_digit_next  = 1'b1;
      if (|product[PROD_WIDTH-1:VALUE_WIDTH]) begin
        overflow_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base     <= BASE_DEC;
      phase           <= PH_DONE;
      accumulator     <= '0;
      negative_sign   <= 1'b0;
      effective_base  <= BASE_DEC;
      char_position   <= '0;
      fallback_offset <= '0;
      seen_digit      <= 1'b0;
      overflow_seen   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        number_base <= cfg_data;
      end
      if (take) begin
        phase           <= phase_next;
        accumulator     <= accumulator_next;
        negative_sign   <= negative_sign_next;
        effective_base  <= effective_base_next;
        char_position   <= char_position_next;
        fallback_offset <= fallback_offset_next;
        seen_digit      <= seen_digit_next;
        overflow_seen   <= overflow_seen_next;
      end
      if (take && emit) begin
        out_valid              <= 1'b1;
        out_data.parsed_value  <= negative_sign_next ? -accumulator_next : accumulator_next;
        out_data.end_offset    <= OFFSET_WIDTH'(emit_offset);
        out_data.digits_found  <= seen_digit_next;
        out_data.overflow_flag <= overflow_seen_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/ascii_integer_parser.sv
// Top level of the ASCII integer parser: input register, parse core, base register port.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in      | input     | in_valid/in_stall  | in_data: char_byte, string_start
//  out     | output    | out_valid/out_stall| out_data: value, offset, flags
//  cfg     | input     | cfg_valid/cfg_ready| cfg_data: number_base
//
// One character per cycle unless a result waits under out_stall. A character moves from
// the input register to the result register, limited by the combinational multiply-add.
// While a result waits under out_stall, the input register holds its character and
// stalls the input, whether or not that character produces a result.
// Synchronous reset clears the parser to its idle state with base ten; cfg_ready is
// always high.
module ascii_integer_parser
  import aip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [BASE_WIDTH-1:0] cfg_data
);

  in_stage_t stage;
  logic      take;

  assign cfg_ready = 1'b1;

  aip_input_reg u_input_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .stage    (stage)
  );

  aip_parse_core u_parse_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: src/aip_checker.sv
// Port-level checker for the ASCII integer parser and its bind to the top level.
module aip_checker
  import aip_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data,
  input logic      cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty result register");

  a_no_digit_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.digits_found |->
      (out_data.parsed_value == 0) && (out_data.end_offset == 0) && !out_data.overflow_flag)
    else $error("result without digits is not zero");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("base register port not ready");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

FILE: sim/ascii_integer_parser_test.sv
// Self-checking testbench for the ASCII integer parser: drives strings, predicts each parse.
`timescale 1ns / 1ps

class parse_tracker;
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_BLANK, SCAN_SIGN, SCAN_ZERO, SCAN_PREFIX, SCAN_DIGITS
  } scan_t;

  logic [aip_pkg::BASE_WIDTH-1:0]     base_reg;
  logic [aip_pkg::BASE_WIDTH-1:0]     radix;
  scan_t                              scan;
  logic [63:0]                        acc;
  bit                                 neg;
  logic [aip_pkg::POSITION_WIDTH-1:0] pos;
  logic [aip_pkg::POSITION_WIDTH-1:0] zero_pos;
  bit                                 got_digit;
  bit                                 wrapped;
  aip_pkg::out_item_t                 expected_numbers[$];
  int                                 errors;

  function new();
    base_reg = aip_pkg::BASE_DEC;
    radix = aip_pkg::BASE_DEC;
    scan = SCAN_IDLE;
    acc = '0;
    neg = 0;
    pos = '0;
    zero_pos = '0;
    got_digit = 0;
    wrapped = 0;
    errors = 0;
  endfunction

  function void write_base(logic [aip_pkg::BASE_WIDTH-1:0] b);
    base_reg = b;
  endfunction

  function int pending();
    return expected_numbers.size();
  endfunction

  function logic [aip_pkg::POSITION_WIDTH-1:0] bump(logic [aip_pkg::POSITION_WIDTH-1:0] p);
    return (p == aip_pkg::POS_MAX) ? p : p + 1'b1;
  endfunction

  function logic [aip_pkg::BASE_WIDTH-1:0] digit_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return 6'(c - "0");
    if (c >= "a" && c <= "z") return 6'(c - "a" + 10);
    if (c >= "A" && c <= "Z") return 6'(c - "A" + 10);
    return 6'd36;
  endfunction

  function void take(logic [aip_pkg::BASE_WIDTH-1:0] d);
    logic [69:0] full;
    full = 70'(acc) * 70'(radix) + 70'(d);
    if (full[69:64] != '0) wrapped = 1;
    acc = full[63:0];
    got_digit = 1;
  endfunction

  function void finish_string(logic [aip_pkg::POSITION_WIDTH-1:0] ofs);
    aip_pkg::out_item_t r;
    r.parsed_value = neg ? -acc : acc;
    r.end_offset = 16'(ofs);
    r.digits_found = got_digit;
    r.overflow_flag = wrapped;
    expected_numbers.push_back(r);
    scan = SCAN_IDLE;
  endfunction

  function void note_char(aip_pkg::in_item_t it);
    logic [7:0]                     c;
    logic [aip_pkg::BASE_WIDTH-1:0] d;
    c = it.char_byte;
    if (it.string_start) begin
      acc = '0;
      neg = 0;
      pos = '0;
      zero_pos = '0;
      got_digit = 0;
      wrapped = 0;
      radix = base_reg;
      if (radix == aip_pkg::BASE_INVALID || radix > aip_pkg::BASE_MAX) begin
        finish_string('0);
        return;
      end
      scan = SCAN_BLANK;
    end
    if (scan == SCAN_IDLE) return;
    if (scan == SCAN_BLANK) begin
      if (c == aip_pkg::CHAR_SPACE || (c >= aip_pkg::CHAR_TAB && c <= aip_pkg::CHAR_CR)) begin
        pos = bump(pos);
        return;
      end
      scan = SCAN_SIGN;
      if (c == aip_pkg::CHAR_MINUS || c == aip_pkg::CHAR_PLUS) begin
        neg = (c == aip_pkg::CHAR_MINUS);
        pos = bump(pos);
        return;
      end
    end
    if (scan == SCAN_SIGN) begin
      if (c == aip_pkg::CHAR_ZERO) begin
        got_digit = 1;
        zero_pos = bump(pos);
        pos = zero_pos;
        scan = SCAN_ZERO;
        return;
      end
      if (radix == aip_pkg::BASE_AUTO) radix = aip_pkg::BASE_DEC;
      scan = SCAN_DIGITS;
    end
    if (scan == SCAN_ZERO) begin
      if ((c == aip_pkg::CHAR_LO_X || c == aip_pkg::CHAR_UP_X) &&
          (radix == aip_pkg::BASE_AUTO || radix == aip_pkg::BASE_HEX)) begin
        radix = aip_pkg::BASE_HEX;
        scan = SCAN_PREFIX;
        pos = bump(pos);
        return;
      end
      if ((c == aip_pkg::CHAR_LO_B || c == aip_pkg::CHAR_UP_B) &&
          (radix == aip_pkg::BASE_AUTO || radix == aip_pkg::BASE_BIN)) begin
        radix = aip_pkg::BASE_BIN;
        scan = SCAN_PREFIX;
        pos = bump(pos);
        return;
      end
      if (radix == aip_pkg::BASE_AUTO) radix = aip_pkg::BASE_OCT;
      scan = SCAN_DIGITS;
    end
    d = digit_of(c);
    if (scan == SCAN_PREFIX) begin
      if (d < radix) begin
        take(d);
        scan = SCAN_DIGITS;
        pos = bump(pos);
      end else begin
        finish_string(zero_pos);
      end
      return;
    end
    if (d < radix) begin
      take(d);
      pos = bump(pos);
      return;
    end
    finish_string(got_digit ? pos : '0);
  endfunction

  function void check_number(aip_pkg::out_item_t got);
    aip_pkg::out_item_t want;
    if (expected_numbers.size() == 0) begin
      $error("unexpected result: value %0d offset %0d", got.parsed_value, got.end_offset);
      errors++;
      return;
    end
    want = expected_numbers.pop_front();
    if (got.parsed_value !== want.parsed_value) begin
      $error("parsed_value: expected %0d, got %0d", want.parsed_value, got.parsed_value);
      errors++;
    end
    if (got.end_offset !== want.end_offset) begin
      $error("end_offset: expected %0d, got %0d", want.end_offset, got.end_offset);
      errors++;
    end
    if (got.digits_found !== want.digits_found) begin
      $error("digits_found: expected %0b, got %0b", want.digits_found, got.digits_found);
      errors++;
    end
    if (got.overflow_flag !== want.overflow_flag) begin
      $error("overflow_flag: expected %0b, got %0b", want.overflow_flag, got.overflow_flag);
      errors++;
    end
  endfunction
endclass

module ascii_integer_parser_test;
  import aip_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [BASE_WIDTH-1:0] BASE_TOP = '1;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [BASE_WIDTH-1:0] cfg_data;

  parse_tracker          book;
  logic [7:0]            text_q[$];
  logic [BASE_WIDTH-1:0] current_base;
  int                    send_pct;
  int                    stall_pct;
  int                    hold_left;
  int                    sent;
  int                    cycle_count;

  ascii_integer_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) book.write_base(cfg_data);
      if (in_valid && !in_stall) book.note_char(in_data);
      if (out_valid && !out_stall) book.check_number(out_data);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ascii_integer_parser_test: errors");
    $finish;
  end

  task automatic send_char(input logic [7:0] c, input bit first);
    in_item_t item;
    int       gap;
    item.char_byte = c;
    item.string_start = first;
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
    gap = 0;
    while ($urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_text(input bit jumble);
    foreach (text_q[i]) send_char(text_q[i], i == 0 || (jumble && $urandom_range(9) == 0));
  endtask

  task automatic send_string(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    text_q.push_back(8'h00);
    send_text(0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
  endtask

  task automatic set_base(input logic [BASE_WIDTH-1:0] b);
    drain();
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= b;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    current_base = b;
  endtask

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return CHAR_ZERO + 8'(v);
    return ($urandom_range(1) ? CHAR_LO_A : CHAR_UP_A) + 8'(v - 10);
  endfunction

  function automatic logic [BASE_WIDTH-1:0] pick_base();
    case ($urandom_range(9))
      0, 9: return BASE_AUTO;
      1: return BASE_DEC;
      2: return BASE_HEX;
      3: return BASE_BIN;
      4: return BASE_OCT;
      5: return BASE_MAX;
      6: return 6'($urandom_range(2, 36));
      7: return BASE_INVALID;
      default: return 6'($urandom_range(37, 63));
    endcase
  endfunction

  task automatic compose_number();
    int  digit_base;
    int  n;
    int  r;
    text_q.delete();
    if (current_base >= BASE_BIN && current_base <= BASE_MAX) digit_base = current_base;
    else if (current_base == BASE_AUTO) digit_base = 10;
    else digit_base = 36;
    repeat ($urandom_range(3)) begin
      r = $urandom_range(5);
      text_q.push_back(r == 0 ? CHAR_SPACE : CHAR_TAB + 8'(r - 1));
    end
    case ($urandom_range(2))
      1: text_q.push_back(CHAR_PLUS);
      2: text_q.push_back(CHAR_MINUS);
      default: ;
    endcase
    case ($urandom_range(5))
      0: begin
        text_q.push_back(CHAR_ZERO);
        if (current_base == BASE_AUTO) digit_base = 8;
      end
      1: begin
        text_q.push_back(CHAR_ZERO);
        text_q.push_back($urandom_range(1) ? CHAR_LO_X : CHAR_UP_X);
        if (current_base == BASE_AUTO) digit_base = 16;
      end
      2: begin
        text_q.push_back(CHAR_ZERO);
        text_q.push_back($urandom_range(1) ? CHAR_LO_B : CHAR_UP_B);
        if (current_base == BASE_AUTO) digit_base = 2;
      end
      default: ;
    endcase
    n = ($urandom_range(7) == 0) ? $urandom_range(20, 70) : $urandom_range(8);
    repeat (n) begin
      if ($urandom_range(9) == 0) text_q.push_back(digit_char($urandom_range(35)));
      else text_q.push_back(digit_char($urandom_range(digit_base - 1)));
    end
    case ($urandom_range(3))
      0: text_q.push_back(8'h00);
      1: text_q.push_back(8'($urandom_range(255)));
      2: text_q.push_back(digit_char(35));
      default: text_q.push_back(CHAR_SPACE);
    endcase
  endtask

  task automatic run_random(input int spct, input int rpct, input int count);
    int target;
    int r;
    send_pct = spct;
    stall_pct = rpct;
    target = sent + count;
    while (sent < target) begin
      if ($urandom_range(7) == 0) set_base(pick_base());
      r = $urandom_range(9);
      if (r < 7) begin
        compose_number();
        send_text(0);
      end else if (r < 9) begin
        text_q.delete();
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
        send_text(1);
      end else begin
        repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)), 1'b0);
      end
    end
  endtask

  initial begin
    book = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    current_base = BASE_DEC;
    send_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_string("-12");
    send_char(8'hFF, 1'b0);
    send_char("5", 1'b1);
    send_char(" ", 1'b1);
    send_char("9", 1'b0);
    send_char("q", 1'b0);
    send_string("+%");
    set_base(BASE_AUTO);
    send_string("\t0xg");
    send_string("0B1");
    send_string("017");
    set_base(BASE_INVALID);
    send_char("A", 1'b1);
    set_base(BASE_MAX);
    send_string("zZ");
    set_base(BASE_BIN);
    send_char("1", 1'b1);
    set_base(BASE_HEX);
    send_char("1", 1'b0);
    send_char(8'h00, 1'b0);
    set_base(BASE_TOP);
    send_char("7", 1'b1);

    run_random(10, 71, 150);
    run_random(71, 10, 150);
    run_random(0, 0, 150);

    set_base(BASE_DEC);
    stall_pct = 0;
    hold_left = 300;
    repeat (40) send_string("7");
    drain();
    repeat ($urandom_range(5, 20)) @(negedge clk);
    repeat (10) send_string("-99");

    drain();
    repeat (20) @(posedge clk);
    if (book.errors == 0) begin
      $display("ascii_integer_parser_test: clean");
    end else begin
      $display("ascii_integer_parser_test: errors");
    end
    $finish;
  end
endmodule

FILE: ascii_integer_parser.f
src/aip_pkg.sv
src/aip_input_reg.sv
src/aip_parse_core.sv
src/ascii_integer_parser.sv
src/aip_checker.sv
sim/ascii_integer_parser_test.sv
